/* sv/isc_pkg.sv */
// ----------------------------------------------------------------------------
// irrigation slot controller package
// shared types, codes and field widths of the slot controller
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int SLOT_COUNT_DEF  = 8;
  localparam int VALVE_SLOTS_DEF = 8;

  localparam int IDX_W   = 4;
  localparam int THR_W   = 10;
  localparam int MOIST_W = 11;
  localparam int TIME_W  = 32;
  localparam int MASK_W  = 8;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd600000;

  typedef enum logic [1:0] {
    OP_ASSIGN = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_EMPTY    = 2'd0,
    MODE_SELECTED = 2'd1,
    MODE_WATERING = 2'd2,
    MODE_ERROR    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_START   = 2'd1,
    EV_STOP    = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_t;

endpackage

/* sv/irrigation_slot_controller_core.sv */
// ----------------------------------------------------------------------------
// irrigation slot controller core
// per-slot mode machines driving valve mask and pump from request stream
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   s_axis_tdata, 64 bits
// m_axis    out        m_axis_tvalid/m_axis_tready   m_axis_tdata, 16 bits
// cfg       in         cfg_valid/cfg_ready           cfg_data, watering timeout ms
//
// one request per cycle sustained unless m_axis stalls; a request passes from the
// input register to the result register, slot update done between them in one pass
// rst (synchronous) empties all slots and loads the timeout with 600000 ms
// a stalled result holds m_axis; the input register still takes a request
// while it is empty, or while the result register is free or drained that cycle
// cfg_ready is always high; write the timeout only while the block is idle
//
module irrigation_slot_controller_core
  import isc_pkg::*;
#(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int VALVE_SLOTS = VALVE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], slot_index[5:2], moisture_threshold[15:6], moisture[26:16],
  // now_ms[58:27], zero fill [63:59]
  input  logic [63:0] s_axis_tdata,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // accepted[0], slot_status[2:1], event_code[4:3], valve_mask[12:5],
  // pump_on[13], zero fill [15:14]
  output logic [15:0] m_axis_tdata,
  // timeout register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // timeout register
  logic [TIME_W-1:0] timeout_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ms <= cfg_data;
    end
  end

  // input register
  logic               in_valid;
  opcode_t            in_op;
  logic [IDX_W-1:0]   in_idx;
  logic [THR_W-1:0]   in_thr;
  logic [MOIST_W-1:0] in_moist;
  logic [TIME_W-1:0]  in_now;

  logic advance;

  // result register frees when empty or drained this cycle
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op    <= opcode_t'(s_axis_tdata[1:0]);
      in_idx   <= s_axis_tdata[5:2];
      in_thr   <= s_axis_tdata[15:6];
      in_moist <= s_axis_tdata[26:16];
      in_now   <= s_axis_tdata[58:27];
    end
  end

  // per-slot state
  mode_t             slot_mode      [SLOT_COUNT];
  mode_t             slot_mode_next [SLOT_COUNT];
  logic [THR_W-1:0]  slot_thr       [SLOT_COUNT];
  logic [TIME_W-1:0] watering_start [SLOT_COUNT];

  // addressed slot
  logic              hit;
  logic [SLOT_W-1:0] sel;
  mode_t             cur_mode;
  logic [THR_W-1:0]  cur_thr;
  logic [TIME_W-1:0] cur_start;

  assign hit       = ({1'b0, in_idx} < (IDX_W+1)'(SLOT_COUNT));
  assign sel       = in_idx[SLOT_W-1:0];
  assign cur_mode  = slot_mode[sel];
  assign cur_thr   = slot_thr[sel];
  assign cur_start = watering_start[sel];

  // moisture compares, a negative sample fails both
  logic              moist_neg;
  logic              moist_below;
  logic              moist_at_or_above;
  logic [TIME_W-1:0] elapsed;
  logic              timed_out;

  assign moist_neg         = in_moist[MOIST_W-1];
  assign moist_below       = !moist_neg && ({1'b0, in_moist[THR_W-1:0]} < {1'b0, cur_thr});
  assign moist_at_or_above = !moist_neg && ({1'b0, in_moist[THR_W-1:0]} >= {1'b0, cur_thr});
  assign elapsed           = in_now - cur_start;
  assign timed_out         = elapsed > timeout_ms;

  // slot transition
  mode_t             new_mode;
  event_t            new_event;
  logic              start_we;
  logic [TIME_W-1:0] start_val;
  logic              thr_we;

  always_comb begin
    new_mode  = cur_mode;
    new_event = EV_NONE;
    start_we  = 1'b0;
    start_val = '0;
    thr_we    = 1'b0;
    case (in_op)
      OP_ASSIGN: begin
        new_mode = MODE_SELECTED;
        thr_we   = 1'b1;
        start_we = 1'b1;
      end
      OP_CLEAR: begin
        new_mode = MODE_EMPTY;
        start_we = 1'b1;
      end
      OP_SAMPLE: begin
        case (cur_mode)
          MODE_SELECTED: begin
            if (moist_below) begin
              new_mode  = MODE_WATERING;
              new_event = EV_START;
              start_we  = 1'b1;
              start_val = in_now;
            end
          end
          MODE_WATERING: begin
            if (moist_at_or_above) begin
              new_mode  = MODE_SELECTED;
              new_event = EV_STOP;
              start_we  = 1'b1;
            end else if (timed_out) begin
              new_mode  = MODE_ERROR;
              new_event = EV_TIMEOUT;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    slot_mode_next = slot_mode;
    if (advance && hit) begin
      slot_mode_next[sel] = new_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_mode[i] <= MODE_EMPTY;
      end
    end else begin
      slot_mode <= slot_mode_next;
    end
  end

  // thresholds and start times are only read in selected or watering,
  // which a slot first reaches only through an assign, so they need no reset
  always_ff @(posedge clk) begin
    if (advance && hit) begin
      if (thr_we) begin
        slot_thr[sel] <= in_thr;
      end
      if (start_we) begin
        watering_start[sel] <= start_val;
      end
    end
  end

  // valve mask from the updated modes
  logic [MASK_W-1:0] mask_next;

  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < SLOT_COUNT && g < VALVE_SLOTS) begin : g_valve
      assign mask_next[g] = (slot_mode_next[g] == MODE_WATERING);
    end else begin : g_none
      assign mask_next[g] = 1'b0;
    end
  end

  // result register
  logic              res_accepted;
  mode_t             res_status;
  event_t            res_event;
  logic [MASK_W-1:0] res_mask;
  logic              res_pump;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_accepted <= hit;
      res_status   <= hit ? new_mode : MODE_ERROR;
      res_event    <= hit ? new_event : EV_NONE;
      res_mask     <= mask_next;
      res_pump     <= |mask_next;
    end
  end

  assign m_axis_tdata = {2'b00, res_pump, res_mask, res_event, res_status, res_accepted};

  // checks
  a_pump_or: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res_pump == (|res_mask)))
    else $error("pump bit disagrees with valve mask");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !res_accepted) |-> (res_status == MODE_ERROR && res_event == EV_NONE))
    else $error("rejected request reported an event or a slot mode");

  a_start_waters: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_event == EV_START) |-> (res_status == MODE_WATERING))
    else $error("watering start without watering mode");

  a_stop_selected: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_event == EV_STOP) |-> (res_status == MODE_SELECTED))
    else $error("watering stop without selected mode");

  a_ready_only_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while result register free");

endmodule
